### hdl/bounded_lifo_stack_assert.svh
// assertion macros used by the checker file
`ifndef BOUNDED_LIFO_STACK_ASSERT_SVH
`define BOUNDED_LIFO_STACK_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define BLSTK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define BLSTK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/blstk_pkg.sv
package blstk_pkg;

  // request kinds
  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_PEEK = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;
  localparam logic [1:0] STAT_BADPOS    = 2'd3;

  // field widths
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 7;

  localparam logic [WORD_W-1:0] ERR_WORD = '1;
  localparam logic [COUNT_W-1:0] CAP_RESET = 7'd64;

  // controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

### hdl/blstk_ram.sv
module blstk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/bounded_lifo_stack.sv
// bounded lifo stack of 32-bit words, entries held in a single-port-pair ram
// push and error results are registered in the cycle after acceptance; pop
// and peek with data pass the read state first; throughput: one word per
// cycle for push while results are taken, none during a pop or peek ram read
// reset (synchronous, active low): count 0, capacity 64, ram contents kept
module bounded_lifo_stack #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_push_value,
  input  logic [6:0]         in_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_data,
  output logic [1:0]         out_status,
  output logic [6:0]         out_count,
  output logic               out_is_empty,
  output logic               out_is_full
);
  import blstk_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [COUNT_W-1:0] DEPTH_SAT =
    (DEPTH > 127) ? 7'd127 : COUNT_W'(DEPTH);

  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   cap_r;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]    out_data_r, out_data_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;
  logic                 out_is_empty_r, out_is_empty_nxt;
  logic                 out_is_full_r, out_is_full_nxt;

  logic                 accept;
  logic [COUNT_W-1:0]   eff_cap;
  logic [COUNT_W-1:0]   op_count;
  logic [1:0]           op_status;
  logic [WORD_W-1:0]    op_data;
  logic                 op_read;
  logic                 op_write;
  logic [COUNT_W-1:0]   rd_idx;
  logic [WORD_W-1:0]    ram_rdata;

  // capacity clamped to 1..DEPTH (at most 127)
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = 7'd1;
    end else if (cap_r > DEPTH_SAT) begin
      eff_cap = DEPTH_SAT;
    end else begin
      eff_cap = cap_r;
    end
  end

  // decode of the offered request
  always_comb begin
    op_count  = count_r;
    op_status = STAT_OK;
    op_data   = '0;
    op_read   = 1'b0;
    op_write  = 1'b0;
    rd_idx    = '0;
    case (in_kind)
      KIND_PUSH: begin
        if (count_r >= eff_cap) begin
          op_status = STAT_OVERFLOW;
        end else begin
          op_write = 1'b1;
          op_count = count_r + 7'd1;
        end
      end
      KIND_POP: begin
        if (count_r == '0) begin
          op_status = STAT_UNDERFLOW;
          op_data   = ERR_WORD;
        end else begin
          op_read  = 1'b1;
          op_count = count_r - 7'd1;
          rd_idx   = count_r - 7'd1;
        end
      end
      KIND_PEEK: begin
        if (in_position == '0 || in_position > count_r) begin
          op_status = STAT_BADPOS;
          op_data   = ERR_WORD;
        end else begin
          op_read = 1'b1;
          rd_idx  = count_r - in_position;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // next state, count and result register
  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_data_nxt     = out_data_r;
    out_status_nxt   = out_status_r;
    out_count_nxt    = out_count_r;
    out_is_empty_nxt = out_is_empty_r;
    out_is_full_nxt  = out_is_full_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          count_nxt        = op_count;
          out_status_nxt   = op_status;
          out_count_nxt    = op_count;
          out_is_empty_nxt = (op_count == '0);
          out_is_full_nxt  = (op_count >= eff_cap);
          out_data_nxt     = op_data;
          if (op_read) begin
            state_nxt = ST_READ;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_READ: begin
        out_data_nxt  = ram_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r     <= out_data_nxt;
    out_status_r   <= out_status_nxt;
    out_count_r    <= out_count_nxt;
    out_is_empty_r <= out_is_empty_nxt;
    out_is_full_r  <= out_is_full_nxt;
  end

  // entry store
  blstk_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept && op_write),
    .waddr (AW'(count_r)),
    .wdata (in_push_value),
    .re    (accept && op_read),
    .raddr (AW'(rd_idx)),
    .rdata (ram_rdata)
  );

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;
  assign out_is_empty = out_is_empty_r;
  assign out_is_full  = out_is_full_r;

endmodule

### hdl/blstk_checker.sv
`include "bounded_lifo_stack_assert.svh"

module blstk_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_data,
  input logic [1:0]         out_status,
  input logic [6:0]         out_count,
  input logic               out_is_empty,
  input logic               out_is_full
);
  import blstk_pkg::*;

  logic stalled;
  logic uflow_word;
  logic oflow_word;

  // result-side conditions
  assign stalled    = out_valid && !out_ready;
  assign uflow_word = out_valid && (out_status == STAT_UNDERFLOW);
  assign oflow_word = out_valid && (out_status == STAT_OVERFLOW);

  // a stalled word keeps its data
  `BLSTK_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_data), "stalled word changed")

  // empty flag tracks the reported count
  `BLSTK_ASSERT_NOW(a_empty_flag, out_valid, out_is_empty == (out_count == 7'd0), "bad empty flag")

  // underflow leaves an empty stack and the error word
  `BLSTK_ASSERT_NOW(a_underflow, uflow_word, out_data == -32'sd1 && out_is_empty, "bad underflow")

  // overflow only on a full stack
  `BLSTK_ASSERT_NOW(a_overflow, oflow_word, out_is_full && out_data == 32'sd0, "bad overflow")

endmodule

bind bounded_lifo_stack blstk_checker u_blstk_checker (.*);
